>>> rtl/ecf_pkg.sv
package ecf_pkg;

	// Table geometry
	localparam int MAX_PATH_ENTRIES = 8;
	localparam int SLOT_W = $clog2(MAX_PATH_ENTRIES);

	// Operand widths
	localparam int RATE_W  = 48;
	localparam int DIVD_W  = 64;
	localparam int STEP_W  = $clog2(DIVD_W);
	localparam int MULA_W  = 41;

	localparam logic [19:0]       USEC_PER_SEC = 20'd1000000;
	localparam logic [RATE_W-1:0] RATE_MAX     = '1;

	// Command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_ACK    = 3'd2;
	localparam logic [2:0] CMD_LOSS   = 3'd3;
	localparam logic [2:0] CMD_REPORT = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_SEGMENT  = 2'd0;
	localparam logic [1:0] REG_REFRESH  = 2'd1;
	localparam logic [1:0] REG_MIN_RATE = 2'd2;
	localparam logic [1:0] REG_DEF_RTT  = 2'd3;

	// Register reset values
	localparam logic [15:0] SEGMENT_RST  = 16'd1200;
	localparam logic [15:0] REFRESH_RST  = 16'd10;
	localparam logic [19:0] MIN_RATE_RST = 20'd1000;
	localparam logic [23:0] DEF_RTT_RST  = 24'd100000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REFRESH,
		ST_RDIV,
		ST_COMP,
		ST_CDIV,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// Request into the shared divider
	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [RATE_W-1:0] divisor;
	} div_req_t;

	// Answer from the shared divider
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/ecf_div.sv
module ecf_div import ecf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [RATE_W:0]   rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [RATE_W-1:0] dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [RATE_W:0] trial;
	logic            fits;

	// One quotient bit a cycle, restoring
	assign trial = {rem_q[RATE_W-1:0], quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_no_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> req.divisor != '0)
		else $error("divider started with zero divisor");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider restarted while busy");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a running division");

endmodule

>>> rtl/earliest_completion_path_scheduler.sv
// Earliest-completion-first path scheduler.
//
// Input channel (in_valid/in_ready) takes one command beat: add, remove, ack,
// loss or selection report. Only a selection report with last_report set
// gives a result beat on the output channel (out_valid/out_ready); every
// other command is absorbed. Configuration writes go through cfg_valid /
// cfg_ready (always ready), one register per beat; the user must write
// only while the block is idle; the block itself does not enforce it.
//
// One beat is handled at a time; in_ready is low while it is worked on.
// A rate refresh needing cwnd*1e6/rtt and the completion estimate on a
// report with a nonzero rate both run through one shared 64-bit divider
// that retires one quotient bit per cycle.
//
// Reset clears the path table, the chosen path, the switch counter and the
// pass state, and loads the register defaults. A result waits in the output
// register while the receiver stalls; further beats are still taken until
// another result would need that register, then the block holds there.
module earliest_completion_path_scheduler import ecf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// Command beats
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  path_id,
	input  logic        path_active,
	input  logic [47:0] path_bandwidth,
	input  logic [31:0] path_cwnd,
	input  logic [31:0] path_srtt,
	input  logic [39:0] byte_count,
	input  logic [31:0] now_ms,
	input  logic        last_report,
	// Result beats
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [7:0]  primary_path,
	output logic        backup_valid,
	output logic [7:0]  backup_path,
	output logic [63:0] best_completion_us,
	output logic [31:0] switch_total
);

	state_t state_q, state_d;

	// Registers
	logic [15:0] seg_q;
	logic [15:0] intv_q;
	logic [19:0] minr_q;
	logic [23:0] drtt_q;

	// Captured beat
	logic [2:0]  cmd_q;
	logic [7:0]  id_q;
	logic        active_q;
	logic [47:0] bw_q;
	logic [31:0] cwnd_q;
	logic [31:0] srtt_q;
	logic [39:0] bytes_q;
	logic [31:0] now_q;
	logic        last_q;

	// Path table
	logic                 ent_valid_q    [MAX_PATH_ENTRIES];
	logic [7:0]           ent_id_q       [MAX_PATH_ENTRIES];
	logic [39:0]          ent_inflight_q [MAX_PATH_ENTRIES];
	logic [RATE_W-1:0]    ent_rate_q     [MAX_PATH_ENTRIES];
	logic [31:0]          ent_rtt_q      [MAX_PATH_ENTRIES];
	logic [31:0]          ent_stamp_q    [MAX_PATH_ENTRIES];

	logic [SLOT_W-1:0] slot_q;
	logic              after_comp_q;
	logic [63:0]       t_q;

	// Selection state
	logic [7:0]  chosen_id_q;
	logic        chosen_valid_q;
	logic [31:0] switch_q;
	logic [7:0]  best_id_q;
	logic [63:0] best_time_q;
	logic [7:0]  second_id_q;
	logic [63:0] second_time_q;
	logic        best_found_q;
	logic        second_found_q;

	logic        out_valid_q;
	logic        status_q;
	logic [7:0]  primary_q;
	logic        backup_valid_q;
	logic [7:0]  backup_q;
	logic [63:0] best_us_q;

	logic              hit;
	logic [SLOT_W-1:0] hit_idx;
	logic              free;
	logic [SLOT_W-1:0] free_idx;
	logic              stale;
	logic              need_div;
	logic              in_beat;
	logic              emit;
	logic              do_switch;
	logic [MULA_W-1:0] mul_a;
	logic [63:0]       product;
	logic [RATE_W-1:0] sat_rate;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	function automatic logic [RATE_W-1:0] raise_min(logic [RATE_W-1:0] r, logic [19:0] m);
		logic [RATE_W-1:0] mw;
		mw = {{(RATE_W-20){1'b0}}, m};
		return (r < mw) ? mw : r;
	endfunction

	ecf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Lowest valid slot holding the id, lowest free slot
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int i = MAX_PATH_ENTRIES - 1; i >= 0; i--) begin
			if (ent_valid_q[i] && ent_id_q[i] == id_q) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!ent_valid_q[i]) begin
				free     = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign stale    = (now_q - ent_stamp_q[hit_idx]) > {16'b0, intv_q};
	assign need_div = bw_q == '0 && cwnd_q != '0 && ent_rtt_q[slot_q] != '0;

	// Shared constant multiplier feeding the divider
	assign mul_a   = (state_q == ST_REFRESH) ? {9'b0, cwnd_q}
	                 : MULA_W'(ent_inflight_q[slot_q]) + MULA_W'(seg_q);
	assign product = 64'(mul_a) * 64'(USEC_PER_SEC);

	always_comb begin
		div_req.start    = (state_q == ST_REFRESH && need_div) ||
		                   (state_q == ST_COMP && ent_rate_q[slot_q] != '0);
		div_req.dividend = product;
		div_req.divisor  = (state_q == ST_REFRESH) ? {16'b0, ent_rtt_q[slot_q]}
		                   : ent_rate_q[slot_q];
	end

	assign sat_rate  = (div_rsp.quotient[63:RATE_W] != '0) ? RATE_MAX
	                   : div_rsp.quotient[RATE_W-1:0];
	assign in_beat   = in_valid && in_ready;
	assign emit      = state_q == ST_FINISH && last_q && (!out_valid_q || out_ready);
	assign do_switch = best_found_q && (!chosen_valid_q || chosen_id_q != best_id_q);

	// Sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = state_q == ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				priority if (cmd_q == CMD_ADD) begin
					if (hit || free) state_d = ST_REFRESH;
				end else if (cmd_q == CMD_ACK) begin
					if (hit) state_d = ST_REFRESH;
				end else if (cmd_q == CMD_REPORT) begin
					if (!active_q) state_d = ST_FINISH;
					else if (hit) state_d = stale ? ST_REFRESH : ST_COMP;
					else if (free) state_d = ST_REFRESH;
					else state_d = ST_FINISH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REFRESH: begin
				if (need_div) state_d = ST_RDIV;
				else state_d = after_comp_q ? ST_COMP : ST_IDLE;
			end
			ST_RDIV: begin
				if (div_rsp.done) state_d = after_comp_q ? ST_COMP : ST_IDLE;
			end
			ST_COMP: begin
				state_d = (ent_rate_q[slot_q] != '0) ? ST_CDIV : ST_UPDATE;
			end
			ST_CDIV: begin
				if (div_rsp.done) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!last_q || emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= SEGMENT_RST;
			intv_q <= REFRESH_RST;
			minr_q <= MIN_RATE_RST;
			drtt_q <= DEF_RTT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SEGMENT:  seg_q  <= cfg_data[15:0];
				REG_REFRESH:  intv_q <= cfg_data[15:0];
				REG_MIN_RATE: minr_q <= cfg_data[19:0];
				REG_DEF_RTT:  drtt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture of the command beat
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q    <= cmd;
			id_q     <= path_id;
			active_q <= path_active;
			bw_q     <= path_bandwidth;
			cwnd_q   <= path_cwnd;
			srtt_q   <= path_srtt;
			bytes_q  <= byte_count;
			now_q    <= now_ms;
			last_q   <= last_report;
		end
	end

	// Table valid bits and chosen path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATH_ENTRIES; i++) ent_valid_q[i] <= 1'b0;
			chosen_id_q    <= '0;
			chosen_valid_q <= 1'b0;
			switch_q       <= '0;
		end else begin
			if (state_q == ST_DECODE) begin
				if (cmd_q == CMD_REMOVE) begin
					if (hit) ent_valid_q[hit_idx] <= 1'b0;
					if (chosen_valid_q && chosen_id_q == id_q) chosen_valid_q <= 1'b0;
				end else if (!hit && free &&
				             (cmd_q == CMD_ADD || (cmd_q == CMD_REPORT && active_q))) begin
					ent_valid_q[free_idx] <= 1'b1;
				end
			end
			if (emit && do_switch) begin
				chosen_id_q    <= best_id_q;
				chosen_valid_q <= 1'b1;
				switch_q       <= switch_q + 1'b1;
			end
		end
	end

	// Table payload, slot and completion time
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DECODE: begin
				after_comp_q <= cmd_q == CMD_REPORT;
				if (hit) begin
					slot_q <= hit_idx;
					if (cmd_q == CMD_ACK || cmd_q == CMD_LOSS)
						ent_inflight_q[hit_idx] <= (ent_inflight_q[hit_idx] >= bytes_q)
						                           ? ent_inflight_q[hit_idx] - bytes_q : '0;
				end else if (free) begin
					slot_q <= free_idx;
					if (cmd_q == CMD_ADD || (cmd_q == CMD_REPORT && active_q)) begin
						ent_id_q[free_idx]       <= id_q;
						ent_inflight_q[free_idx] <= '0;
						ent_rate_q[free_idx]     <= {{(RATE_W-20){1'b0}}, minr_q};
						ent_rtt_q[free_idx]      <= {8'b0, drtt_q};
						ent_stamp_q[free_idx]    <= now_q;
					end
				end
			end
			ST_REFRESH: begin
				if (!need_div) begin
					ent_rate_q[slot_q]  <= raise_min(bw_q != '0 ? bw_q : ent_rate_q[slot_q],
					                                 minr_q);
					ent_stamp_q[slot_q] <= now_q;
					if (srtt_q != '0) ent_rtt_q[slot_q] <= srtt_q;
				end
			end
			ST_RDIV: begin
				if (div_rsp.done) begin
					ent_rate_q[slot_q]  <= raise_min(sat_rate, minr_q);
					ent_stamp_q[slot_q] <= now_q;
					if (srtt_q != '0) ent_rtt_q[slot_q] <= srtt_q;
				end
			end
			ST_COMP: begin
				t_q <= '1;
			end
			ST_CDIV: begin
				if (div_rsp.done) t_q <= div_rsp.quotient + 64'(ent_rtt_q[slot_q]);
			end
			default: ;
		endcase
	end

	// Best and second-best of the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_id_q      <= '0;
			best_time_q    <= '1;
			second_id_q    <= '0;
			second_time_q  <= '1;
			best_found_q   <= 1'b0;
			second_found_q <= 1'b0;
		end else if (state_q == ST_UPDATE) begin
			if (t_q < best_time_q) begin
				second_id_q    <= best_id_q;
				second_time_q  <= best_time_q;
				second_found_q <= best_found_q;
				best_id_q      <= id_q;
				best_time_q    <= t_q;
				best_found_q   <= 1'b1;
			end else if (t_q < second_time_q) begin
				second_id_q    <= id_q;
				second_time_q  <= t_q;
				second_found_q <= 1'b1;
			end
		end else if (emit) begin
			best_id_q      <= '0;
			best_time_q    <= '1;
			second_id_q    <= '0;
			second_time_q  <= '1;
			best_found_q   <= 1'b0;
			second_found_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q       <= !best_found_q;
			primary_q      <= best_found_q ? best_id_q : '0;
			backup_valid_q <= best_found_q && second_found_q;
			backup_q       <= (best_found_q && second_found_q) ? second_id_q : '0;
			best_us_q      <= best_found_q ? best_time_q : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign primary_path       = primary_q;
	assign backup_valid       = backup_valid_q;
	assign backup_path        = backup_q;
	assign best_completion_us = best_us_q;
	assign switch_total       = switch_q;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ecf_pkg::*;

	localparam int SLOTS      = MAX_PATH_ENTRIES;
	localparam int DRAIN_WAIT = 200;
	localparam int STALL_MAX  = 5000;
	localparam logic [2:0] CMD_BOGUS5 = 3'd5;
	localparam logic [2:0] CMD_BOGUS6 = 3'd6;
	localparam logic [2:0] CMD_BOGUS7 = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  id;
		logic        active;
		logic [47:0] bw;
		logic [31:0] cwnd;
		logic [31:0] srtt;
		logic [39:0] bytes;
		logic [31:0] now;
		logic        last;
	} path_cmd_t;

	typedef struct {
		logic        status;
		logic [7:0]  primary;
		logic        bvalid;
		logic [7:0]  backup;
		logic [63:0] best;
		logic [31:0] switches;
	} choice_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic [7:0] path_id = '0;
	logic path_active = 1'b0;
	logic [47:0] path_bandwidth = '0;
	logic [31:0] path_cwnd = '0;
	logic [31:0] path_srtt = '0;
	logic [39:0] byte_count = '0;
	logic [31:0] now_ms = '0;
	logic last_report = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic [7:0] primary_path;
	logic backup_valid;
	logic [7:0] backup_path;
	logic [63:0] best_completion_us;
	logic [31:0] switch_total;

	earliest_completion_path_scheduler uut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the scheduler
	logic        tbl_valid [SLOTS];
	logic [7:0]  tbl_id [SLOTS];
	logic [39:0] tbl_inflight [SLOTS];
	logic [47:0] tbl_rate [SLOTS];
	logic [31:0] tbl_rtt [SLOTS];
	logic [31:0] tbl_stamp [SLOTS];
	logic [7:0]  sel_id;
	logic        sel_valid;
	logic [31:0] sel_switches;
	logic [7:0]  run_best_id, run_second_id;
	logic [63:0] run_best_t, run_second_t;
	logic        run_best_ok, run_second_ok;
	logic [15:0] seg_bytes;
	logic [15:0] refresh_ms;
	logic [19:0] rate_floor;
	logic [23:0] fresh_rtt;

	path_cmd_t cmd_backlog[$];
	choice_t   due_choices[$];
	path_cmd_t cur_beat;
	int        mismatches = 0;
	int        choices_seen = 0;
	int        quiet_cycles = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	bit        idle_en = 1'b1;
	logic [31:0] clock_ms = 32'd1000;

	function automatic void clear_run();
		run_best_id = '0;
		run_second_id = '0;
		run_best_t = '1;
		run_second_t = '1;
		run_best_ok = 1'b0;
		run_second_ok = 1'b0;
	endfunction

	function automatic int find_slot(logic [7:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic int claim_slot(logic [7:0] id, logic [31:0] now);
		for (int i = 0; i < SLOTS; i++)
			if (!tbl_valid[i]) begin
				tbl_valid[i] = 1'b1;
				tbl_id[i] = id;
				tbl_inflight[i] = '0;
				tbl_rate[i] = 48'(rate_floor);
				tbl_rtt[i] = 32'(fresh_rtt);
				tbl_stamp[i] = now;
				return i;
			end
		return -1;
	endfunction

	function automatic void rate_update(int s, path_cmd_t b);
		logic [63:0] q;
		if (b.bw != '0) begin
			tbl_rate[s] = b.bw;
		end else if (b.cwnd != '0 && tbl_rtt[s] != '0) begin
			q = (64'(b.cwnd) * 64'd1000000) / 64'(tbl_rtt[s]);
			tbl_rate[s] = (q > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
		end
		if (tbl_rate[s] < 48'(rate_floor)) tbl_rate[s] = 48'(rate_floor);
		if (b.srtt != '0) tbl_rtt[s] = b.srtt;
		tbl_stamp[s] = b.now;
	endfunction

	function automatic logic [63:0] eta_us(int s);
		if (tbl_rate[s] == '0) return '1;
		return ((64'(tbl_inflight[s]) + 64'(seg_bytes)) * 64'd1000000) / 64'(tbl_rate[s])
			+ 64'(tbl_rtt[s]);
	endfunction

	// Advance the shadow state by one command beat; queue any choice it yields
	function automatic void predict_choice(path_cmd_t b);
		int s;
		logic [63:0] t;
		choice_t c;
		case (b.op)
			CMD_ADD: begin
				s = find_slot(b.id);
				if (s < 0) s = claim_slot(b.id, b.now);
				if (s >= 0) rate_update(s, b);
				return;
			end
			CMD_REMOVE: begin
				s = find_slot(b.id);
				if (s >= 0) tbl_valid[s] = 1'b0;
				if (sel_valid && sel_id == b.id) sel_valid = 1'b0;
				return;
			end
			CMD_ACK, CMD_LOSS: begin
				s = find_slot(b.id);
				if (s < 0) return;
				tbl_inflight[s] = (tbl_inflight[s] >= b.bytes) ? tbl_inflight[s] - b.bytes : '0;
				if (b.op == CMD_ACK) rate_update(s, b);
				return;
			end
			CMD_REPORT: ;
			default: return;
		endcase
		if (b.active) begin
			s = find_slot(b.id);
			if (s < 0) begin
				s = claim_slot(b.id, b.now);
				if (s >= 0) rate_update(s, b);
			end
			if (s >= 0) begin
				if (b.now - tbl_stamp[s] > 32'(refresh_ms)) rate_update(s, b);
				t = eta_us(s);
				if (t < run_best_t) begin
					run_second_id = run_best_id;
					run_second_t = run_best_t;
					run_second_ok = run_best_ok;
					run_best_id = b.id;
					run_best_t = t;
					run_best_ok = 1'b1;
				end else if (t < run_second_t) begin
					run_second_id = b.id;
					run_second_t = t;
					run_second_ok = 1'b1;
				end
			end
		end
		if (!b.last) return;
		if (run_best_ok) begin
			if (!sel_valid || sel_id != run_best_id) begin
				sel_id = run_best_id;
				sel_valid = 1'b1;
				sel_switches++;
			end
			c.status = 1'b0;
			c.primary = run_best_id;
			c.bvalid = run_second_ok;
			c.backup = run_second_ok ? run_second_id : 8'd0;
			c.best = run_best_t;
		end else begin
			c.status = 1'b1;
			c.primary = '0;
			c.bvalid = 1'b0;
			c.backup = '0;
			c.best = '0;
		end
		c.switches = sel_switches;
		due_choices.push_back(c);
		clear_run();
	endfunction

	// Beat with random content, time mostly moving forward with an occasional random jump
	function automatic path_cmd_t rand_beat(logic [2:0] op, logic [7:0] id);
		path_cmd_t b;
		b.op = op;
		b.id = id;
		b.active = ($urandom_range(9) != 0);
		case ($urandom_range(3))
			0: b.bw = '0;
			1: b.bw = 48'($urandom_range(1, 100000));
			2: b.bw = 48'({$urandom, $urandom});
			default: b.bw = 48'($urandom_range(1000000, 50000000));
		endcase
		b.cwnd = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
		case ($urandom_range(3))
			0: b.srtt = '0;
			1: b.srtt = $urandom;
			default: b.srtt = 32'($urandom_range(1, 500000));
		endcase
		b.bytes = 40'({$urandom, $urandom});
		if ($urandom_range(49) == 0) clock_ms = $urandom;
		else clock_ms = clock_ms + 32'($urandom_range(0, 30));
		b.now = clock_ms;
		b.last = 1'b0;
		return b;
	endfunction

	function automatic path_cmd_t fixed_beat(logic [2:0] op, logic [7:0] id, logic [47:0] bw,
			logic [31:0] cwnd, logic [31:0] srtt, logic active, logic last);
		path_cmd_t b;
		b = rand_beat(op, id);
		b.bw = bw;
		b.cwnd = cwnd;
		b.srtt = srtt;
		b.active = active;
		b.last = last;
		return b;
	endfunction

	// Up to four management commands followed by a selection pass over a pool of ids
	function automatic void build_traffic(int n);
		int k, base, pool;
		path_cmd_t b;
		logic [2:0] op;
		while (n > 0) begin
			base = ($urandom_range(3) == 0) ? $urandom_range(0, 243) : 0;
			pool = $urandom_range(3, 12);
			k = $urandom_range(0, 4);
			repeat (k) begin
				case ($urandom_range(9))
					0, 1, 2: op = CMD_ADD;
					3: op = CMD_REMOVE;
					4, 5: op = CMD_ACK;
					6: op = CMD_LOSS;
					7: op = 3'($urandom_range(5, 7));
					default: op = CMD_ADD;
				endcase
				cmd_backlog.push_back(rand_beat(op, 8'(base + $urandom_range(0, pool - 1))));
				n--;
			end
			k = $urandom_range(1, 10);
			for (int i = 0; i < k; i++) begin
				b = rand_beat(CMD_REPORT,
					($urandom_range(19) == 0) ? 8'($urandom) : 8'(base + $urandom_range(0, pool - 1)));
				b.last = (i == k - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
				cmd_backlog.push_back(b);
				n--;
			end
		end
	endfunction

	// Command driver
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) predict_choice(cur_beat);
			if (cmd_backlog.size() > 0 && !(idle_en && $urandom_range(99) < 37)) begin
				cur_beat = cmd_backlog.pop_front();
				in_valid <= 1'b1;
				cmd <= cur_beat.op;
				path_id <= cur_beat.id;
				path_active <= cur_beat.active;
				path_bandwidth <= cur_beat.bw;
				path_cwnd <= cur_beat.cwnd;
				path_srtt <= cur_beat.srtt;
				byte_count <= cur_beat.bytes;
				now_ms <= cur_beat.now;
				last_report <= cur_beat.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver
	always @(posedge clk) begin
		choice_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				choices_seen++;
				if (due_choices.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: primary %0d switches %0d",
							primary_path, switch_total);
					mismatches++;
				end else begin
					e = due_choices.pop_front();
					if (status !== e.status || primary_path !== e.primary
						|| backup_valid !== e.bvalid || backup_path !== e.backup
						|| best_completion_us !== e.best || switch_total !== e.switches) begin
						if (mismatches < 10)
							$display("result mismatch: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
								e.status, e.primary, e.bvalid, e.backup, e.best, e.switches,
								status, primary_path, backup_valid, backup_path,
								best_completion_us, switch_total);
						mismatches++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (!hold_done && choices_seen == 40) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_en && $urandom_range(99) < 37);
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= STALL_MAX) begin
				$display("CHECKS FAILED");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SEGMENT:  seg_bytes = data[15:0];
			REG_REFRESH:  refresh_ms = data[15:0];
			REG_MIN_RATE: rate_floor = data[19:0];
			REG_DEF_RTT:  fresh_rtt = data[23:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (cmd_backlog.size() == 0 && !in_valid && due_choices.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] seg, logic [15:0] refr, logic [19:0] floor_rate,
			logic [23:0] rtt0);
		write_reg(REG_SEGMENT, 24'(seg));
		write_reg(REG_REFRESH, 24'(refr));
		write_reg(REG_MIN_RATE, 24'(floor_rate));
		write_reg(REG_DEF_RTT, rtt0);
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_inflight[i] = '0;
			tbl_rate[i] = '0;
			tbl_rtt[i] = '0;
			tbl_stamp[i] = '0;
		end
		sel_id = '0;
		sel_valid = 1'b0;
		sel_switches = '0;
		clear_run();
		seg_bytes = SEGMENT_RST;
		refresh_ms = REFRESH_RST;
		rate_floor = MIN_RATE_RST;
		fresh_rtt = DEF_RTT_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ties, empty pass, unknown ids, bogus commands, saturation, full table
		cmd_backlog.push_back(fixed_beat(CMD_ADD, 8'd0, '1, 32'd0, 32'd50, 1'b1, 1'b0));
		cmd_backlog.push_back(fixed_beat(CMD_ADD, 8'd255, '1, 32'd0, 32'd50, 1'b1, 1'b0));
		cmd_backlog.push_back(fixed_beat(CMD_REPORT, 8'd0, '0, 32'd0, 32'd0, 1'b1, 1'b0));
		cmd_backlog.push_back(fixed_beat(CMD_REPORT, 8'd255, '0, 32'd0, 32'd0, 1'b1, 1'b1));
		cmd_backlog.push_back(fixed_beat(CMD_REPORT, 8'd7, '0, 32'd0, 32'd0, 1'b0, 1'b1));
		cmd_backlog.push_back(fixed_beat(CMD_ACK, 8'd9, '0, '1, '1, 1'b1, 1'b0));
		cmd_backlog.push_back(fixed_beat(CMD_LOSS, 8'd0, '0, 32'd0, 32'd0, 1'b1, 1'b0));
		cmd_backlog.push_back(fixed_beat(CMD_REMOVE, 8'd0, '0, 32'd0, 32'd0, 1'b1, 1'b0));
		cmd_backlog.push_back(fixed_beat(CMD_BOGUS5, 8'd1, '0, 32'd0, 32'd0, 1'b1, 1'b1));
		cmd_backlog.push_back(fixed_beat(CMD_BOGUS6, 8'd1, '0, 32'd0, 32'd0, 1'b1, 1'b1));
		cmd_backlog.push_back(fixed_beat(CMD_BOGUS7, 8'd1, '0, 32'd0, 32'd0, 1'b1, 1'b1));
		cmd_backlog.push_back(fixed_beat(CMD_ADD, 8'd1, '0, '1, 32'd1, 1'b1, 1'b0));
		cmd_backlog.push_back(fixed_beat(CMD_ADD, 8'd1, '0, '1, 32'd0, 1'b1, 1'b0));
		for (int i = 0; i < 9; i++)
			cmd_backlog.push_back(fixed_beat(CMD_REPORT, 8'(20 + i), 48'(1 + i), 32'd0, 32'd0,
				1'b1, i == 8));
		drain();

		// Random phases over a spread of register settings
		build_traffic(260);
		drain();
		set_regs(16'd1, 16'd0, 20'd1, 24'd1);
		build_traffic(260);
		drain();
		set_regs(16'hFFFF, 16'hFFFF, 20'd1000000, 24'd10000000);
		idle_en = 1'b0;
		build_traffic(260);
		drain();
		idle_en = 1'b1;
		set_regs(16'd1500, 16'd5, 20'd0, 24'hFFFFFF);
		build_traffic(260);
		drain();
		set_regs(16'd9000, 16'd20, 20'hFFFFF, 24'd200);
		build_traffic(260);
		drain();
		set_regs(SEGMENT_RST, REFRESH_RST, MIN_RATE_RST, DEF_RTT_RST);
		build_traffic(280);
		drain();

		if (due_choices.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/ecf_pkg.sv
rtl/ecf_div.sv
rtl/earliest_completion_path_scheduler.sv
bench/testbench.sv
